// File: sv/ccr_pkg.sv
// Shared types and constants of the character canvas rasterizer.
// Used by ccr_frame_mem, ccr_seq and character_canvas_rasterizer_top.
`default_nettype none
package ccr_pkg;

  localparam int unsigned DefMaxCols = 64;
  localparam int unsigned DefMaxRows = 64;
  localparam logic [7:0]  SpaceChar  = 8'h20;
  localparam logic [6:0]  DefCanvasWidth  = 7'd64;
  localparam logic [6:0]  DefCanvasHeight = 7'd64;

  typedef enum logic [2:0] {
    ACT_CLEAR = 3'd0,
    ACT_POINT = 3'd1,
    ACT_RECT  = 3'd2,
    ACT_FILL  = 3'd3,
    ACT_RING  = 3'd4,
    ACT_DISC  = 3'd5,
    ACT_LINE  = 3'd6,
    ACT_READ  = 3'd7
  } action_e;

  typedef enum logic {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    action_e           action;
    logic signed [7:0] xa;
    logic signed [7:0] ya;
    logic signed [7:0] xb;
    logic signed [7:0] yb;
    logic [6:0]        radius;
    logic [7:0]        glyph;
  } cmd_t;

  // Coordinates are always below 128, so seven bits carry either axis.
  typedef struct packed {
    logic       we;
    logic [6:0] wx;
    logic [6:0] wy;
    logic [7:0] wdata;
    logic       re;
    logic [6:0] rx;
    logic [6:0] ry;
  } mem_req_t;

endpackage
`default_nettype wire

// File: sv/ccr_frame_mem.sv
// Frame store: one write and one registered read port, addressed by row and column.
// Depends on ccr_pkg for the request struct.
`default_nettype none
module ccr_frame_mem #(
  parameter int unsigned MAX_COLS = ccr_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = ccr_pkg::DefMaxRows
) (
  input  wire logic              clk_i,
  input  wire ccr_pkg::mem_req_t req_i,
  output logic [7:0]             rdata_o
);

  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned Depth = 2 ** (CW + RW);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[{req_i.wy[RW-1:0], req_i.wx[CW-1:0]}] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[{req_i.ry[RW-1:0], req_i.rx[CW-1:0]}];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: sv/ccr_seq.sv
// Command sequencer: clear sweeps, canvas scans, Bresenham steps, reads and result register.
// Depends on ccr_pkg; drives ccr_frame_mem through a mem_req_t.
`default_nettype none
module ccr_seq #(
  parameter int unsigned MAX_COLS = ccr_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = ccr_pkg::DefMaxRows
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire ccr_pkg::cmd_t     cmd_i,
  input  wire logic [7:0]        cols_i,
  input  wire logic [7:0]        rows_i,
  output ccr_pkg::mem_req_t      req_o,
  input  wire logic [7:0]        rdata_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output logic [7:0]             res_char_o,
  output logic                   res_inside_o
);

  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_LINE  = 6'b001000,
    S_RESP  = 6'b010000,
    S_HOLD  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  ccr_pkg::cmd_t cmd_q;
  logic [CW-1:0] sx_q, sx_d;
  logic [RW-1:0] sy_q, sy_d;
  logic signed [7:0]  lx_q, lx_d, ly_q, ly_d;
  logic signed [10:0] err_q, err_d;
  logic signed [10:0] ldx_q, ldx_d, ldy_q, ldy_d;
  logic lsx_q, lsx_d, lsy_q, lsy_d;
  logic rd_in_q, rd_in_d;
  logic res_v_q, res_v_d;
  logic [7:0] res_c_q, res_c_d;
  logic res_i_q, res_i_d;

  logic accept;
  logic in_on, line_on;
  logic sx_last, sy_last;
  logic hit;
  logic signed [9:0] px, py, xa10, ya10, xb10, yb10, ddx, ddy;
  logic [19:0] sqx, sqy;
  logic [19:0] d2;
  logic [13:0] rr;
  logic signed [20:0] ring_diff;
  logic signed [8:0] dxs, dys;
  logic signed [11:0] e2;

  function automatic logic on_canvas(logic signed [7:0] x, logic signed [7:0] y,
                                     logic [7:0] cols, logic [7:0] rows);
    return !x[7] && ({1'b0, x[6:0]} < cols) && !y[7] && ({1'b0, y[6:0]} < rows);
  endfunction

  assign accept  = cmd_valid_i && cmd_ready_o;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign in_on   = on_canvas(cmd_i.xa, cmd_i.ya, cols_i, rows_i);
  assign line_on = on_canvas(lx_q, ly_q, cols_i, rows_i);
  assign sx_last = ({{(8-CW){1'b0}}, sx_q} == cols_i - 8'd1);
  assign sy_last = ({{(8-RW){1'b0}}, sy_q} == rows_i - 8'd1);

  // Shape membership of the scanned pixel
  assign px   = $signed({{(10-CW){1'b0}}, sx_q});
  assign py   = $signed({{(10-RW){1'b0}}, sy_q});
  assign xa10 = 10'(cmd_q.xa);
  assign ya10 = 10'(cmd_q.ya);
  assign xb10 = 10'(cmd_q.xb);
  assign yb10 = 10'(cmd_q.yb);
  assign ddx  = px - xa10;
  assign ddy  = py - ya10;
  assign sqx  = 20'(ddx * ddx);
  assign sqy  = 20'(ddy * ddy);
  assign d2   = sqx + sqy;
  assign rr   = 14'(cmd_q.radius * cmd_q.radius);
  assign ring_diff = $signed({1'b0, d2}) - $signed({7'd0, rr});

  always_comb begin
    case (cmd_q.action)
      ccr_pkg::ACT_RECT: begin
        hit = ((py == ya10 || py == yb10) && px >= xa10 && px <= xb10) ||
              ((px == xa10 || px == xb10) && py >= ya10 && py <= yb10);
      end
      ccr_pkg::ACT_FILL: begin
        hit = px >= xa10 && px <= xb10 && py >= ya10 && py <= yb10;
      end
      ccr_pkg::ACT_RING: begin
        hit = (ring_diff <= $signed({14'd0, cmd_q.radius})) &&
              (ring_diff >= -$signed({14'd0, cmd_q.radius}));
      end
      ccr_pkg::ACT_DISC: hit = d2 <= {6'd0, rr};
      default:           hit = 1'b0;
    endcase
  end

  assign dxs = 9'(cmd_i.xb) - 9'(cmd_i.xa);
  assign dys = 9'(cmd_i.yb) - 9'(cmd_i.ya);
  assign e2  = 12'(err_q) <<< 1;

  always_comb begin
    state_d = state_q;
    sx_d = sx_q;
    sy_d = sy_q;
    lx_d = lx_q;
    ly_d = ly_q;
    err_d = err_q;
    ldx_d = ldx_q;
    ldy_d = ldy_q;
    lsx_d = lsx_q;
    lsy_d = lsy_q;
    rd_in_d = rd_in_q;
    res_v_d = res_v_q && !res_ready_i;
    res_c_d = res_c_q;
    res_i_d = res_i_q;
    req_o = '0;

    case (state_q)
      S_CLEAR: begin
        req_o.we    = 1'b1;
        req_o.wx    = 7'(sx_q);
        req_o.wy    = 7'(sy_q);
        req_o.wdata = ccr_pkg::SpaceChar;
        sx_d = sx_q + 1'b1;
        if (&sx_q) begin
          sy_d = sy_q + 1'b1;
          if (&sy_q) state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          sx_d = '0;
          sy_d = '0;
          case (cmd_i.action)
            ccr_pkg::ACT_CLEAR: state_d = S_CLEAR;
            ccr_pkg::ACT_POINT: begin
              req_o.we    = in_on;
              req_o.wx    = cmd_i.xa[6:0];
              req_o.wy    = cmd_i.ya[6:0];
              req_o.wdata = cmd_i.glyph;
            end
            ccr_pkg::ACT_LINE: begin
              lx_d  = cmd_i.xa;
              ly_d  = cmd_i.ya;
              ldx_d = dxs[8] ? -11'(dxs) : 11'(dxs);
              ldy_d = dys[8] ? -11'(dys) : 11'(dys);
              lsx_d = cmd_i.xa < cmd_i.xb;
              lsy_d = cmd_i.ya < cmd_i.yb;
              err_d = (dxs[8] ? -11'(dxs) : 11'(dxs)) - (dys[8] ? -11'(dys) : 11'(dys));
              state_d = S_LINE;
            end
            ccr_pkg::ACT_READ: begin
              req_o.re = in_on;
              req_o.rx = cmd_i.xa[6:0];
              req_o.ry = cmd_i.ya[6:0];
              rd_in_d  = in_on;
              state_d  = S_RESP;
            end
            default: begin
              if (cols_i != 8'd0 && rows_i != 8'd0) state_d = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        req_o.we    = hit;
        req_o.wx    = 7'(sx_q);
        req_o.wy    = 7'(sy_q);
        req_o.wdata = cmd_q.glyph;
        if (sx_last) begin
          sx_d = '0;
          sy_d = sy_q + 1'b1;
          if (sy_last) state_d = S_IDLE;
        end else begin
          sx_d = sx_q + 1'b1;
        end
      end
      S_LINE: begin
        req_o.we    = line_on;
        req_o.wx    = lx_q[6:0];
        req_o.wy    = ly_q[6:0];
        req_o.wdata = cmd_q.glyph;
        if (lx_q == cmd_q.xb && ly_q == cmd_q.yb) begin
          state_d = S_IDLE;
        end else begin
          if (e2 > -12'(ldy_q)) begin
            err_d = err_q - ldy_q;
            lx_d  = lsx_q ? lx_q + 8'sd1 : lx_q - 8'sd1;
          end
          if (e2 < 12'(ldx_q)) begin
            err_d = err_d + ldx_q;
            ly_d  = lsy_q ? ly_q + 8'sd1 : ly_q - 8'sd1;
          end
        end
      end
      S_RESP, S_HOLD: begin
        // hold the read data until the result register frees up
        if (!res_v_q || res_ready_i) begin
          res_v_d = 1'b1;
          res_c_d = rd_in_q ? rdata_i : 8'd0;
          res_i_d = rd_in_q;
          state_d = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      sx_q    <= '0;
      sy_q    <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_i;
    lx_q    <= lx_d;
    ly_q    <= ly_d;
    err_q   <= err_d;
    ldx_q   <= ldx_d;
    ldy_q   <= ldy_d;
    lsx_q   <= lsx_d;
    lsy_q   <= lsy_d;
    rd_in_q <= rd_in_d;
    res_c_q <= res_c_d;
    res_i_q <= res_i_d;
  end

  assign res_valid_o  = res_v_q;
  assign res_char_o   = res_c_q;
  assign res_inside_o = res_i_q;

endmodule
`default_nettype wire

// File: sv/character_canvas_rasterizer_top.sv
// Character canvas rasterizer top level: stream ports, size registers, sequencer and frame store.
// Depends on ccr_pkg, ccr_seq and ccr_frame_mem.
//
// Usage: each beat on the s_axis channel is one drawing command, the action in tuser.
// Only a read command produces a beat on m_axis: the stored character in tdata and the
// on-canvas flag in tuser. The user writes the size registers through the cfg channel (index 0
// width, index 1 height) only while no command is in flight; the block does not enforce it.
// Work per command, bound by the single frame-store write port (one pixel per cycle):
//   point: a single write; read: a registered read, plus any wait on m_axis;
//   rectangle, fill, ring, disc: a scan of the visible canvas (width * height in use);
//   line: one write per point on the line (one Bresenham step per cycle);
//   clear: MAX_COLS' * MAX_ROWS' writes where each is rounded up to a power of two.
// After reset the store is swept to spaces as by a clear; s_axis_tready stays low meanwhile,
// and cfg writes are still taken. When the receiver stalls, a read result holds in the output
// register and the next command waits only if it is a read as well.
`default_nettype none
module character_canvas_rasterizer_top #(
  parameter int unsigned MAX_COLS = ccr_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = ccr_pkg::DefMaxRows
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // xa, ya, xb, yb, radius, glyph, pad
  input  wire logic [2:0]  s_axis_tuser,  // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // pixel_char
  output logic             m_axis_tuser,  // inside_res
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);

  localparam logic [7:0] MaxC = 8'(MAX_COLS);
  localparam logic [7:0] MaxR = 8'(MAX_ROWS);

  logic [6:0] width_q, height_q;
  logic [7:0] cols, rows;
  ccr_pkg::cmd_t cmd;
  ccr_pkg::mem_req_t req;
  logic [7:0] rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ccr_pkg::DefCanvasWidth;
      height_q <= ccr_pkg::DefCanvasHeight;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ccr_pkg::REG_CANVAS_WIDTH:  width_q  <= cfg_data_i;
        ccr_pkg::REG_CANVAS_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturate oversized sizes to the store dimensions
  assign cols = ({1'b0, width_q}  > MaxC) ? MaxC : {1'b0, width_q};
  assign rows = ({1'b0, height_q} > MaxR) ? MaxR : {1'b0, height_q};

  assign cmd.action = ccr_pkg::action_e'(s_axis_tuser);
  assign cmd.xa     = s_axis_tdata[7:0];
  assign cmd.ya     = s_axis_tdata[15:8];
  assign cmd.xb     = s_axis_tdata[23:16];
  assign cmd.yb     = s_axis_tdata[31:24];
  assign cmd.radius = s_axis_tdata[38:32];
  assign cmd.glyph  = s_axis_tdata[46:39];

  ccr_seq #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_o  (s_axis_tready),
    .cmd_i        (cmd),
    .cols_i       (cols),
    .rows_i       (rows),
    .req_o        (req),
    .rdata_i      (rdata),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_char_o   (m_axis_tdata),
    .res_inside_o (m_axis_tuser)
  );

  ccr_frame_mem #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_mem (
    .clk_i,
    .req_i   (req),
    .rdata_o (rdata)
  );

endmodule
`default_nettype wire

// File: sim/ccr_checker.sv
// Checker for the character canvas rasterizer: watches the cfg, s_axis and m_axis beats.
// Keeps its own copy of the frame store and size registers, predicts read results.
// Depends on ccr_pkg only.
module ccr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          reads_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ccr_pkg::*;

  typedef struct {
    logic [7:0] pixel;
    logic       on_cnv;
  } read_res_t;

  logic [7:0] canvas_q [4096];
  logic [6:0] width_q, height_q;
  read_res_t  read_res_q [$];

  assign pending_o = read_res_q.size();

  function automatic int cols_used();
    return (width_q > 64) ? 64 : int'(width_q);
  endfunction

  function automatic int rows_used();
    return (height_q > 64) ? 64 : int'(height_q);
  endfunction

  function automatic bit on_canvas(int x, int y);
    return x >= 0 && x < cols_used() && y >= 0 && y < rows_used();
  endfunction

  task automatic plot(int x, int y, logic [7:0] g);
    if (on_canvas(x, y)) canvas_q[y * 64 + x] = g;
  endtask

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic draw_circle(int cx, int cy, int r, logic [7:0] g, bit ring);
    int d2;
    for (int y = cy - r; y <= cy + r; y++) begin
      for (int x = cx - r; x <= cx + r; x++) begin
        d2 = (x - cx) * (x - cx) + (y - cy) * (y - cy);
        if (ring ? (iabs(d2 - r * r) <= r) : (d2 <= r * r)) plot(x, y, g);
      end
    end
  endtask

  task automatic draw_line(int x, int y, int xe, int ye, logic [7:0] g);
    int dx, dy, sx, sy, err, e2;
    dx  = iabs(xe - x);
    dy  = iabs(ye - y);
    sx  = (x < xe) ? 1 : -1;
    sy  = (y < ye) ? 1 : -1;
    err = dx - dy;
    forever begin
      plot(x, y, g);
      if (x == xe && y == ye) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
  endtask

  task automatic apply_cmd(action_e act, logic [47:0] d);
    int xa, ya, xb, yb, r;
    logic [7:0] g;
    read_res_t res;
    xa = int'($signed(d[7:0]));
    ya = int'($signed(d[15:8]));
    xb = int'($signed(d[23:16]));
    yb = int'($signed(d[31:24]));
    r  = int'(d[38:32]);
    g  = d[46:39];
    case (act)
      ACT_CLEAR: foreach (canvas_q[i]) canvas_q[i] = SpaceChar;
      ACT_POINT: plot(xa, ya, g);
      ACT_RECT: begin
        for (int x = xa; x <= xb; x++) begin
          plot(x, ya, g);
          plot(x, yb, g);
        end
        for (int y = ya; y <= yb; y++) begin
          plot(xa, y, g);
          plot(xb, y, g);
        end
      end
      ACT_FILL: begin
        for (int y = ya; y <= yb; y++)
          for (int x = xa; x <= xb; x++) plot(x, y, g);
      end
      ACT_RING: draw_circle(xa, ya, r, g, 1'b1);
      ACT_DISC: draw_circle(xa, ya, r, g, 1'b0);
      ACT_LINE: draw_line(xa, ya, xb, yb, g);
      default: begin
        res.on_cnv = on_canvas(xa, ya);
        res.pixel  = res.on_cnv ? canvas_q[ya * 64 + xa] : 8'h00;
        read_res_q.push_back(res);
        reads_o++;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    read_res_t exp_res;
    if (!rst_ni) begin
      foreach (canvas_q[i]) canvas_q[i] = SpaceChar;
      width_q    = DefCanvasWidth;
      height_q   = DefCanvasHeight;
      fail_cnt_o = 0;
      reads_o    = 0;
      read_res_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_reg_e'(cfg_index_i) == REG_CANVAS_WIDTH) width_q = cfg_data_i;
        else height_q = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) apply_cmd(action_e'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (read_res_q.size() == 0) begin
          $error("unexpected result beat: pixel_char %h inside_res %b",
                 m_axis_tdata, m_axis_tuser);
          fail_cnt_o++;
        end else begin
          exp_res = read_res_q.pop_front();
          if (m_axis_tdata !== exp_res.pixel) begin
            $error("pixel_char: expected %h, got %h", exp_res.pixel, m_axis_tdata);
            fail_cnt_o++;
          end
          if (m_axis_tuser !== exp_res.on_cnv) begin
            $error("inside_res: expected %b, got %b", exp_res.on_cnv, m_axis_tuser);
            fail_cnt_o++;
          end
        end
      end
    end
  end
endmodule

// File: sim/character_canvas_rasterizer_top_test.sv
// Testbench top for the character canvas rasterizer: clock, reset, command and cfg stimulus.
// Checking is done by ccr_checker; depends on ccr_pkg and character_canvas_rasterizer_top.
module character_canvas_rasterizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ccr_pkg::*;

  localparam int DrainCycles = 4200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // xa, ya, xb, yb, radius, glyph, pad
  logic [2:0]  s_axis_tuser = '0;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // pixel_char
  logic        m_axis_tuser;        // inside_res
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [6:0]  cfg_data_i = '0;

  int fail_cnt, pending, reads, cmd_cnt;
  int send_idle_pct, recv_stall_pct;
  int cur_w = 64, cur_h = 64;

  always #4 clk_i = ~clk_i;

  character_canvas_rasterizer_top u_dut (.*);

  ccr_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .reads_o(reads)
  );

  // Receiver stalls at random, one decision per edge.
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_cmd(action_e act, int xa, int ya, int xb, int yb, int r, int g);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {1'b0, 8'(g), 7'(r), 8'(yb), 8'(xb), 8'(ya), 8'(xa)};
    do @(posedge clk_i); while (!s_axis_tready);
    cmd_cnt++;
  endtask

  task automatic write_reg(cfg_reg_e idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 7'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Let the block finish drawing before the size registers change.
  task automatic set_size(int w, int h);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(REG_CANVAS_WIDTH, w);
    write_reg(REG_CANVAS_HEIGHT, h);
    cur_w = (w > 64) ? 64 : w;
    cur_h = (h > 64) ? 64 : h;
  endtask

  function automatic int rand_coord(int span);
    if ($urandom_range(9) == 0) return int'($signed(8'($urandom)));
    return int'($urandom_range(0, span + 8)) - 4;
  endfunction

  task automatic rand_cmd();
    int sel, r;
    action_e act;
    sel = $urandom_range(99);
    if (sel < 32) act = ACT_READ;
    else if (sel < 34) act = ACT_CLEAR;
    else act = action_e'($urandom_range(ACT_POINT, ACT_LINE));
    r = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
    send_cmd(act, rand_coord(cur_w), rand_coord(cur_h), rand_coord(cur_w),
             rand_coord(cur_h), r, $urandom_range(0, 255));
  endtask

  task automatic rand_phase(int w, int h, int idle, int stall, int n);
    set_size(w, h);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) rand_cmd();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(REG_CANVAS_WIDTH, 64);
    write_reg(REG_CANVAS_HEIGHT, 64);

    // Directed: extremes, each action, reversed rectangles, degenerate shapes.
    send_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_POINT, 0, 0, 0, 0, 0, 8'hff);
    send_cmd(ACT_POINT, 63, 63, 0, 0, 0, 8'h00);
    send_cmd(ACT_POINT, -128, 127, 0, 0, 0, 8'h41);
    send_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_READ, 63, 63, 0, 0, 0, 0);
    send_cmd(ACT_READ, 127, -128, 0, 0, 0, 0);
    send_cmd(ACT_RECT, 2, 3, 10, 8, 0, 8'h23);
    send_cmd(ACT_RECT, 20, 5, 12, 9, 0, 8'h2a);
    send_cmd(ACT_FILL, 30, 30, 35, 33, 0, 8'h55);
    send_cmd(ACT_FILL, 40, 30, 35, 33, 0, 8'haa);
    send_cmd(ACT_RING, 32, 32, 0, 0, 0, 8'h6f);
    send_cmd(ACT_RING, 50, 12, 0, 0, 9, 8'h6f);
    send_cmd(ACT_DISC, 5, 60, 0, 0, 127, 8'h2e);
    send_cmd(ACT_LINE, 0, 63, 63, 0, 0, 8'h2f);
    send_cmd(ACT_LINE, 127, 127, -128, -128, 0, 8'h5c);
    send_cmd(ACT_LINE, 7, 3, 9, 40, 0, 8'h7c);
    send_cmd(ACT_LINE, 4, 4, 4, 4, 0, 8'h78);
    send_cmd(ACT_READ, 4, 4, 0, 0, 127, 0);
    send_cmd(ACT_READ, 30, 31, 0, 0, 0, 0);
    send_cmd(ACT_READ, -1, 5, 0, 0, 0, 0);
    send_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_READ, 10, 3, 0, 0, 0, 0);

    rand_phase(13, 9, 0, 0, 24);
    rand_phase(127, 3, 68, 0, 24);
    rand_phase(0, 7, 0, 68, 6);
    rand_phase(1, 64, 0, 68, 16);
    rand_phase(20, 127, 7, 7, 24);
    rand_phase(64, 64, 0, 0, 24);

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Ran %0d commands of every action over six canvas sizes, %0d pixel reads.",
             cmd_cnt, reads);
    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule
